[rtl/assert_macros.svh]
// assertion macros for the rtl of the siphash table lookup
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[rtl/sitl_pkg.sv]
// types, constants and helpers of the siphash table lookup
`timescale 1ns / 1ps
package sitl_pkg;

   // table geometry
   localparam int unsigned TABLE_ENTRIES = 65536;
   localparam int TABLE_ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam bit TABLE_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

   // payload widths
   localparam int WORD_W = 64;
   localparam int INDEX_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_SEL_BIT = 3;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // register selects
   localparam logic REG_KEY_LOW = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   // key reset values
   localparam logic [WORD_W-1:0] KEY_LOW_RESET = 64'h0706050403020100;
   localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 64'h0F0E0D0C0B0A0908;

   // siphash initialisation constants
   localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

   // length word of an 8-byte message, and the finalisation mark
   localparam logic [WORD_W-1:0] SIP_LAST = 64'h0800000000000000;
   localparam logic [WORD_W-1:0] SIP_FINAL = 64'h00000000000000ff;

   typedef struct packed {
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic [WORD_W-1:0] v2;
      logic [WORD_W-1:0] v3;
   } sip_state_type;

   typedef struct packed {
      logic                    wr_en;
      logic [TABLE_ADDR_W-1:0] wr_addr;
      logic [WORD_W-1:0]       wr_data;
      logic                    rd_en;
      logic [TABLE_ADDR_W-1:0] rd_addr;
   } table_req_type;

   typedef struct packed {
      logic                    done;
      logic [TABLE_ADDR_W-1:0] remainder;
   } mod_status_type;

   function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                input int unsigned n);
      return (x << n) | (x >> (WORD_W - n));
   endfunction

endpackage

[rtl/sitl_if.sv]
// handshake channels for request and response items
`timescale 1ns / 1ps
interface sitl_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] lookup_key;
   logic [15:0] write_index;
   logic [63:0] write_value;

   modport source (output valid, kind, lookup_key, write_index, write_value, input ready);
   modport sink (input valid, kind, lookup_key, write_index, write_value, output ready);
endinterface

interface sitl_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] stored_value;
   logic [15:0] bucket;

   modport source (output valid, stored_value, bucket, input ready);
   modport sink (input valid, stored_value, bucket, output ready);
endinterface

[rtl/sitl_round.sv]
// siphash half round, the shared arithmetic unit
`timescale 1ns / 1ps
module sitl_round
   import sitl_pkg::*;
(
   input  sip_state_type state_in,
   input  logic          second_half,
   output sip_state_type state_out
);

   logic [WORD_W-1:0] a, b, c, d;
   logic [WORD_W-1:0] a_sum, b_mix, a_rot, c_sum, d_mix;

   // second half works on v2/v1 and v0/v3 with other rotations
   assign a = second_half ? state_in.v2 : state_in.v0;
   assign b = state_in.v1;
   assign c = second_half ? state_in.v0 : state_in.v2;
   assign d = state_in.v3;

   assign a_sum = a + b;
   assign b_mix = (second_half ? rotl64(b, 17) : rotl64(b, 13)) ^ a_sum;
   assign a_rot = rotl64(a_sum, 32);
   assign c_sum = c + d;
   assign d_mix = (second_half ? rotl64(d, 21) : rotl64(d, 16)) ^ c_sum;

   always_comb begin
      state_out.v1 = b_mix;
      state_out.v3 = d_mix;
      if (second_half) begin
         state_out.v0 = c_sum;
         state_out.v2 = a_rot;
      end else begin
         state_out.v0 = a_rot;
         state_out.v2 = c_sum;
      end
   end

endmodule

[rtl/sitl_mod.sv]
// hash reduction modulo the table size
`timescale 1ns / 1ps
module sitl_mod
   import sitl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] hash,
   output mod_status_type    status
);

   generate
      if (TABLE_POW2) begin : g_mask
         logic                    done_ff;
         logic [TABLE_ADDR_W-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= hash[TABLE_ADDR_W-1:0];
            end
         end

         assign status.done = done_ff;
         assign status.remainder = rem_ff;
      end else begin : g_serial
         localparam int RW = TABLE_ADDR_W + 1;
         localparam int BITS_PER_CYCLE = 8;
         localparam int CYCLES = WORD_W / BITS_PER_CYCLE;
         localparam int CNT_W = $clog2(CYCLES);
         localparam logic [RW-1:0] MODULUS = RW'(TABLE_ENTRIES);
         localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CYCLES - 1);

         logic                    busy_ff, done_ff;
         logic [CNT_W-1:0]        cnt_ff;
         logic [TABLE_ADDR_W-1:0] rem_ff, rem_in;
         logic [WORD_W-1:0]       shift_ff;
         logic [RW-1:0]           partial;

         // one compare and subtract per message bit, msb first
         always_comb begin
            partial = {1'b0, rem_ff};
            for (int i = 0; i < BITS_PER_CYCLE; i++) begin
               partial = {partial[RW-2:0], shift_ff[WORD_W-1-i]};
               if (partial >= MODULUS) begin
                  partial = partial - MODULUS;
               end
            end
            rem_in = partial[RW-2:0];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               done_ff <= 1'b0;
               if (start) begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= '0;
               end else if (busy_ff) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (cnt_ff == CNT_LAST) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
            if (start) begin
               rem_ff   <= '0;
               shift_ff <= hash;
            end else if (busy_ff) begin
               rem_ff   <= rem_in;
               shift_ff <= shift_ff << BITS_PER_CYCLE;
            end
         end

         assign status.done = done_ff;
         assign status.remainder = rem_ff;
      end
   endgenerate

endmodule

[rtl/sitl_table.sv]
// value table memory, one write and one registered read port
`timescale 1ns / 1ps
module sitl_table
   import sitl_pkg::*;
(
   input  logic              clock,
   input  table_req_type     tbl_req,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] table_mem_ff [TABLE_ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         table_mem_ff[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         rd_data_ff <= table_mem_ff[tbl_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/siphash_indexed_table_lookup.sv]
// top level: siphash-2-4 keyed table lookup with write and lookup items
//
//  channel   | dir | handshake            | carries
//  ----------+-----+----------------------+-----------------------------------------
//  req_chan  | in  | valid / ready        | kind, lookup_key, write_index, write_value
//  rsp_chan  | out | valid / ready        | stored_value, bucket
//  csr (apb) | in  | psel/penable/pwrite  | hash_key_low at 0x0, hash_key_high at 0x8
//
// a write item is stored as it is accepted and leaves the sequencer idle; a lookup
//   runs 16 half rounds, the reduction and a table read before the next item is
//   taken, set by the single half-round unit that every round of the hash goes through
// with a table size that is not a power of two the reduction is bit-serial
//   instead of a mask
// reset is synchronous, clears the sequencer and the response valid and loads the
//   keys with their reset values; the table has no reset and is defined only where written
// a finished response waits in the output register; the next item is taken
//   meanwhile, and only a second lookup stalls until the first response leaves
`timescale 1ns / 1ps
`include "assert_macros.svh"
module siphash_indexed_table_lookup
   import sitl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sitl_req_if.sink              req_chan,
   sitl_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [WORD_W-1:0]     pwdata,
   output logic [WORD_W-1:0]     prdata,
   output logic                  pready
);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_HASH   = 2'd1;
   localparam logic [1:0] S_REDUCE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   // half-round steps where message and length words are folded in, and the last step
   localparam logic [3:0] STEP_MSG  = 4'd3;
   localparam logic [3:0] STEP_LEN  = 4'd7;
   localparam logic [3:0] STEP_LAST = 4'd15;

   logic [1:0]              state_ff, state_in;
   logic [3:0]              step_ff, step_in;
   logic [WORD_W-1:0]       key_low_ff, key_high_ff;
   sip_state_type           v_ff, v_init, v_step, round_out;
   logic [WORD_W-1:0]       msg_ff;
   logic [WORD_W-1:0]       hash_word;
   logic                    rsp_valid_ff;
   logic [WORD_W-1:0]       stored_value_ff;
   logic [INDEX_W-1:0]      bucket_ff, bucket_hold_ff;
   logic                    req_accept, lookup_start, write_hit;
   logic                    csr_write, rsp_free, mod_start, rsp_load;
   mod_status_type          mod_status;
   table_req_type           tbl_req;
   logic [WORD_W-1:0]       tbl_rd_data;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // only the select bit decodes: the two keys sit eight bytes apart
   assign prdata = (paddr[CSR_SEL_BIT] == REG_KEY_HIGH) ? key_high_ff : key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KEY_LOW_RESET;
         key_high_ff <= KEY_HIGH_RESET;
      end else if (csr_write) begin
         if (paddr[CSR_SEL_BIT] == REG_KEY_HIGH) begin
            key_high_ff <= pwdata;
         end else begin
            key_low_ff <= pwdata;
         end
      end
   end

   // ---------------- request side ----------------
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign lookup_start = req_accept && (req_chan.kind == KIND_LOOKUP);
   // writes past the end of the table are dropped
   assign write_hit = req_accept && (req_chan.kind == KIND_WRITE) &&
                      (32'(req_chan.write_index) < 32'(TABLE_ENTRIES));

   // initial siphash state, message word already folded into v3
   assign v_init.v0 = key_low_ff ^ SIP_C0;
   assign v_init.v1 = key_high_ff ^ SIP_C1;
   assign v_init.v2 = key_low_ff ^ SIP_C2;
   assign v_init.v3 = key_high_ff ^ SIP_C3 ^ req_chan.lookup_key;

   // ---------------- shared round unit ----------------
   sitl_round u_round (
      .state_in    (v_ff),
      .second_half (step_ff[0]),
      .state_out   (round_out)
   );

   // fold in message, length and finalisation mark at round boundaries
   always_comb begin
      v_step = round_out;
      unique case (step_ff)
         STEP_MSG: begin
            v_step.v0 = round_out.v0 ^ msg_ff;
            v_step.v3 = round_out.v3 ^ SIP_LAST;
         end
         STEP_LEN: begin
            v_step.v0 = round_out.v0 ^ SIP_LAST;
            v_step.v2 = round_out.v2 ^ SIP_FINAL;
         end
         default: begin
            v_step = round_out;
         end
      endcase
   end

   // hash taken straight from the last half round
   assign hash_word = round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
   assign mod_start = (state_ff == S_HASH) && (step_ff == STEP_LAST);

   sitl_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .hash   (hash_word),
      .status (mod_status)
   );

   // ---------------- table ----------------
   assign tbl_req.wr_en = write_hit;
   assign tbl_req.wr_addr = TABLE_ADDR_W'(req_chan.write_index);
   assign tbl_req.wr_data = req_chan.write_value;
   assign tbl_req.rd_en = (state_ff == S_REDUCE) && mod_status.done;
   assign tbl_req.rd_addr = mod_status.remainder;

   sitl_table u_table (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   // ---------------- sequencer ----------------
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == S_DONE) && rsp_free;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (lookup_start) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = S_REDUCE;
               step_in = '0;
            end
         end
         S_REDUCE: begin
            if (mod_status.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // hash working state
   always_ff @(posedge clock) begin
      if (lookup_start) begin
         v_ff   <= v_init;
         msg_ff <= req_chan.lookup_key;
      end else if (state_ff == S_HASH) begin
         v_ff <= v_step;
      end
   end

   // bucket captured with the read address, upper bits dropped on large tables
   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         bucket_hold_ff <= INDEX_W'(mod_status.remainder);
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         stored_value_ff <= tbl_rd_data;
         bucket_ff       <= bucket_hold_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.stored_value = stored_value_ff;
   assign rsp_chan.bucket = bucket_ff;

   // ---------------- checks ----------------
   `ASSERT_RST(a_mod_done_in_reduce, clock, reset,
               mod_status.done |-> state_ff == S_REDUCE,
               "reduction finished outside the reduce state")
   `ASSERT_RST(a_step_idle_zero, clock, reset,
               state_ff != S_HASH |-> step_ff == 4'd0,
               "half-round counter not parked outside hashing")
   `ASSERT_RST(a_done_gives_rsp, clock, reset,
               rsp_load |=> rsp_valid_ff && state_ff == S_IDLE,
               "finished lookup did not reach the response register")

endmodule
